// ----- design/nearest_landmark_association_assert.svh -----
// assertion macros shared by the nearest landmark association rtl
// depends on nothing; included by modules that check their own logic
`ifndef NEAREST_LANDMARK_ASSOCIATION_ASSERT_SVH
`define NEAREST_LANDMARK_ASSOCIATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nla assertion failed");

// next-cycle implication, checked out of reset
`define NLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nla assertion failed");

`endif

// ----- design/nla_pkg.sv -----
// shared types and constants for the nearest landmark association block
// no dependencies
package nla_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int ADDR_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam logic [31:0] MAX_U = 32'(MAX_LANDMARKS);

    localparam int ID_W    = 16;
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DIST_W  = SQ_W + 1;
    localparam int CNT_W   = 7;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [ID_W-1:0]           id;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_scan_ctl;

endpackage

// ----- design/nla_lm_mem.sv -----
// landmark table: one write port, one registered read port
// depends on nla_pkg
module nla_lm_mem (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [nla_pkg::ADDR_W-1:0] i_wr_addr,
    input  nla_pkg::t_entry           i_wr_entry,
    input  logic                      i_rd_en,
    input  logic [nla_pkg::ADDR_W-1:0] i_rd_addr,
    output nla_pkg::t_entry           o_rd_entry
);

    nla_pkg::t_entry r_mem [nla_pkg::MAX_LANDMARKS];
    nla_pkg::t_entry r_rd_entry;

    // loads and scans never share a cycle, so no bypass is needed
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ----- design/nla_dist.sv -----
// two-stage squared distance pipe: coordinate difference, then squares
// depends on nla_pkg
module nla_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nla_pkg::t_scan_ctl                  i_ctl,
    input  nla_pkg::t_entry                     i_entry,
    input  logic signed [nla_pkg::COORD_W-1:0]  i_obs_x,
    input  logic signed [nla_pkg::COORD_W-1:0]  i_obs_y,
    output nla_pkg::t_scan_ctl                  o_ctl,
    output nla_pkg::t_entry                     o_entry,
    output logic [nla_pkg::SQ_W-1:0]            o_sq_x,
    output logic [nla_pkg::SQ_W-1:0]            o_sq_y
);

    nla_pkg::t_scan_ctl r_ctl1;
    nla_pkg::t_scan_ctl r_ctl2;
    nla_pkg::t_entry    r_entry1;
    nla_pkg::t_entry    r_entry2;
    logic signed [nla_pkg::DIFF_W-1:0] r_dx;
    logic signed [nla_pkg::DIFF_W-1:0] r_dy;
    logic [nla_pkg::SQ_W-1:0] r_sq_x;
    logic [nla_pkg::SQ_W-1:0] r_sq_y;

    logic signed [nla_pkg::DIFF_W-1:0] w_dx;
    logic signed [nla_pkg::DIFF_W-1:0] w_dy;
    logic signed [2*nla_pkg::DIFF_W-1:0] w_px;
    logic signed [2*nla_pkg::DIFF_W-1:0] w_py;

    assign w_dx = $signed({i_obs_x[nla_pkg::COORD_W-1], i_obs_x})
                - $signed({i_entry.x[nla_pkg::COORD_W-1], i_entry.x});
    assign w_dy = $signed({i_obs_y[nla_pkg::COORD_W-1], i_obs_y})
                - $signed({i_entry.y[nla_pkg::COORD_W-1], i_entry.y});
    // squares are never negative and stay within 2^48
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= w_dx;
        r_dy     <= w_dy;
        r_entry1 <= i_entry;
        r_sq_x   <= w_px[nla_pkg::SQ_W-1:0];
        r_sq_y   <= w_py[nla_pkg::SQ_W-1:0];
        r_entry2 <= r_entry1;
    end

    assign o_ctl   = r_ctl2;
    assign o_entry = r_entry2;
    assign o_sq_x  = r_sq_x;
    assign o_sq_y  = r_sq_y;

endmodule

// ----- design/nearest_landmark_association.sv -----
// channel   dir  handshake            payload
// s (req)   in   i_s_tvalid/o_s_tready tuser req_type, tdata entry/id/x/y
// m (res)   out  o_m_tvalid/i_m_tready tuser found, tdata id/x/y
// cfg       in   i_cfg_wr_en           i_cfg_wr_data landmark_count
//
// a query scans n entries, n being landmark_count capped at the table depth, one
// table read per cycle through the single read port; the next request is accepted
// once the result has moved into the output register
// a query with n = 0 skips the scan and answers with found = 0
// synchronous active-low reset; the table holds no reset value
// a result waiting on the output register does not block the next request;
// a finished scan holds until the output register is free
//
// top level; depends on nla_pkg, nla_lm_mem, nla_dist and the assertion header
`include "nearest_landmark_association_assert.svh"

module nearest_landmark_association (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] entry_index, [21:6] landmark_id, [45:22] point_x, [69:46] point_y, rest 0
    input  logic [71:0] i_s_tdata,
    // [0] req_type
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] nearest_id, [39:16] nearest_x, [63:40] nearest_y
    output logic [63:0] o_m_tdata,
    // [0] found
    output logic        o_m_tuser,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [nla_pkg::CNT_W-1:0] r_count;
    logic signed [nla_pkg::COORD_W-1:0] r_obs_x;
    logic signed [nla_pkg::COORD_W-1:0] r_obs_y;
    logic [nla_pkg::ADDR_W-1:0] r_addr;
    logic [nla_pkg::ADDR_W-1:0] r_last;
    nla_pkg::t_scan_ctl r_rd_ctl;
    logic [nla_pkg::DIST_W-1:0] r_best_dist;
    nla_pkg::t_entry r_best_entry;
    logic r_best_found;
    logic r_out_valid;
    logic r_out_found;
    nla_pkg::t_entry r_out_entry;

    logic s_acc;
    logic s_query;
    logic [5:0] s_index;
    nla_pkg::t_entry s_entry;
    logic [31:0] w_index_ext;
    logic [31:0] w_count_ext;
    logic [31:0] w_n;
    logic w_wr_en;
    logic w_rd_en;
    logic w_out_free;
    nla_pkg::t_scan_ctl w_issue;
    nla_pkg::t_entry w_rd_entry;
    nla_pkg::t_scan_ctl w_cmp_ctl;
    nla_pkg::t_entry w_cmp_entry;
    logic [nla_pkg::SQ_W-1:0] w_sq_x;
    logic [nla_pkg::SQ_W-1:0] w_sq_y;
    logic [nla_pkg::DIST_W-1:0] w_dist;
    logic w_take;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_query    = (i_s_tuser == nla_pkg::REQ_QUERY);
    assign s_index    = i_s_tdata[5:0];
    assign s_entry.id = i_s_tdata[21:6];
    assign s_entry.x  = i_s_tdata[45:22];
    assign s_entry.y  = i_s_tdata[69:46];

    assign w_index_ext = {26'd0, s_index};
    assign w_count_ext = {25'd0, r_count};
    // count above the table depth saturates
    assign w_n = (w_count_ext > nla_pkg::MAX_U) ? nla_pkg::MAX_U : w_count_ext;
    assign w_wr_en = s_acc && !s_query && (w_index_ext < nla_pkg::MAX_U);

    assign w_rd_en       = (r_state == ST_SCAN);
    assign w_issue.valid = w_rd_en;
    assign w_issue.first = (r_addr == '0);
    assign w_issue.last  = (r_addr == r_last);

    nla_lm_mem u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (nla_pkg::ADDR_W'(w_index_ext)),
        .i_wr_entry (s_entry),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_entry (w_rd_entry)
    );

    nla_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_entry (w_rd_entry),
        .i_obs_x (r_obs_x),
        .i_obs_y (r_obs_y),
        .o_ctl   (w_cmp_ctl),
        .o_entry (w_cmp_entry),
        .o_sq_x  (w_sq_x),
        .o_sq_y  (w_sq_y)
    );

    assign w_dist = {1'b0, w_sq_x} + {1'b0, w_sq_y};
    // a later entry must be strictly closer to win
    assign w_take = w_cmp_ctl.valid && (w_cmp_ctl.first || (w_dist < r_best_dist));
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && s_query) begin
                    n_state = (r_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_cmp_ctl.valid && w_cmp_ctl.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= w_issue;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && s_query) begin
            r_obs_x      <= s_entry.x;
            r_obs_y      <= s_entry.y;
            r_addr       <= '0;
            r_last       <= nla_pkg::ADDR_W'(w_n - 32'd1);
            r_best_found <= 1'b0;
            r_best_entry <= '0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_take) begin
                r_best_dist  <= w_dist;
                r_best_entry <= w_cmp_entry;
                r_best_found <= 1'b1;
            end
        end
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_found <= r_best_found;
            r_out_entry <= r_best_entry;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {r_out_entry.y, r_out_entry.x, r_out_entry.id};

    `NLA_ASSERT_IMPLY(a_cmp_in_scan, i_clk, i_rst_n, w_cmp_ctl.valid,
        (r_state == ST_SCAN) || (r_state == ST_DRAIN))
    `NLA_ASSERT_IMPLY(a_addr_in_range, i_clk, i_rst_n, r_state == ST_SCAN, r_addr <= r_last)
    `NLA_ASSERT_NEXT(a_finish_loads_out, i_clk, i_rst_n,
        (r_state == ST_FINISH) && w_out_free, o_m_tvalid && (r_state == ST_IDLE))
    `NLA_ASSERT_IMPLY(a_empty_is_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser,
        o_m_tdata == '0)

endmodule

// ----- verif/tb_nearest_landmark_association.sv -----
// testbench for nearest_landmark_association: loads a landmark map, sets the scan
// count and checks every query answer against an in-bench nearest-neighbor predictor
// depends on nla_pkg and the nearest_landmark_association rtl
module tb_nearest_landmark_association;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS;
    localparam int   ADDR_W        = nla_pkg::ADDR_W;
    localparam int   ID_W          = nla_pkg::ID_W;
    localparam int   COORD_W       = nla_pkg::COORD_W;
    localparam int   DIST_W        = nla_pkg::DIST_W;
    localparam int   CNT_W         = nla_pkg::CNT_W;
    localparam logic REQ_LOAD      = nla_pkg::REQ_LOAD;
    localparam logic REQ_QUERY     = nla_pkg::REQ_QUERY;

    localparam int SETTLE     = 90;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_SHOWN  = 10;
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct {
        logic                      kind;
        logic [ADDR_W-1:0]         slot;
        logic [ID_W-1:0]           ident;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_request;

    typedef struct {
        logic                      found;
        logic [ID_W-1:0]           ident;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;

    // predictor copy of the landmark map and the scan count
    logic [ID_W-1:0]           map_id [MAX_LANDMARKS];
    logic signed [COORD_W-1:0] map_x  [MAX_LANDMARKS];
    logic signed [COORD_W-1:0] map_y  [MAX_LANDMARKS];
    logic [CNT_W-1:0]          lm_count = '0;

    // what the stimulus side has loaded so far, used to keep scans on written slots
    bit                        gen_loaded [MAX_LANDMARKS];
    logic signed [COORD_W-1:0] gen_x [MAX_LANDMARKS];
    logic signed [COORD_W-1:0] gen_y [MAX_LANDMARKS];

    t_request request_q[$];
    t_answer  pending_answers[$];
    t_request cur_req;
    bit       send_busy = 1'b0;
    int       send_gap = 0;
    int       recv_stall = 0;
    bit       no_idle = 1'b0;
    int       err_count = 0;
    int       idle_cycles = 0;

    nearest_landmark_association DUT (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > longint'(C_MAX)) return C_MAX;
        if (v < longint'(C_MIN)) return C_MIN;
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return C_MIN;
        if (r == 1) return C_MAX;
        if (r < 5) return clamp_coord(longint'($urandom_range(0, 4096)) - 2048);
        return COORD_W'($urandom);
    endfunction

    // squared euclidean distance at full width, strictly closer replaces the best
    function automatic t_answer nearest_of(logic signed [COORD_W-1:0] qx,
                                           logic signed [COORD_W-1:0] qy);
        t_answer           a;
        longint            dx;
        longint            dy;
        logic [DIST_W-1:0] cand_dist;
        logic [DIST_W-1:0] best;
        int                n;
        int                j;
        bit                have;
        a.found = 1'b0;
        a.ident = '0;
        a.nx = '0;
        a.ny = '0;
        have = 1'b0;
        best = '0;
        n = (lm_count > MAX_LANDMARKS) ? MAX_LANDMARKS : int'(lm_count);
        for (j = 0; j < n; j++) begin
            dx = longint'(qx) - longint'(map_x[j]);
            dy = longint'(qy) - longint'(map_y[j]);
            cand_dist = DIST_W'(dx * dx + dy * dy);
            if (!have || cand_dist < best) begin
                have = 1'b1;
                best = cand_dist;
                a.found = 1'b1;
                a.ident = map_id[j];
                a.nx = map_x[j];
                a.ny = map_y[j];
            end
        end
        return a;
    endfunction

    task automatic take_request(t_request r);
        if (r.kind == REQ_LOAD) begin
            map_id[r.slot] = r.ident;
            map_x[r.slot] = r.px;
            map_y[r.slot] = r.py;
        end else begin
            pending_answers = {pending_answers, nearest_of(r.px, r.py)};
        end
    endtask

    task automatic push_load(int slot, logic [ID_W-1:0] ident,
                             logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        t_request r;
        r.kind = REQ_LOAD;
        r.slot = ADDR_W'(slot);
        r.ident = ident;
        r.px = x;
        r.py = y;
        gen_loaded[slot] = 1'b1;
        gen_x[slot] = x;
        gen_y[slot] = y;
        request_q = {request_q, r};
    endtask

    task automatic push_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        t_request r;
        r.kind = REQ_QUERY;
        r.slot = ADDR_W'($urandom);    // ignored by a query
        r.ident = ID_W'($urandom);
        r.px = x;
        r.py = y;
        request_q = {request_q, r};
    endtask

    // send_busy also covers a request popped in this time step whose tvalid is not out yet
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || send_busy ||
               pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_count(logic [CNT_W-1:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        lm_count = v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly queries against the loaded map, some reloads and equidistant pairs
    task automatic run_mixed(int items);
        int  i;
        int  r;
        int  n;
        int  s1;
        int  s2;
        int  j;
        longint qx;
        longint qy;
        longint da;
        longint db;
        n = (lm_count > MAX_LANDMARKS) ? MAX_LANDMARKS : int'(lm_count);
        i = 0;
        while (i < items) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                j = $urandom_range(0, MAX_LANDMARKS - 1);
                s1 = $urandom_range(0, MAX_LANDMARKS - 1);
                if ($urandom_range(0, 5) == 0 && gen_loaded[s1])
                    push_load(j, ID_W'($urandom), gen_x[s1], gen_y[s1]);
                else
                    push_load(j, ID_W'($urandom), rand_coord(), rand_coord());
                i++;
            end else if (r < 31 && n >= 2) begin
                // two slots at the same distance from the query, lower index must win
                s1 = $urandom_range(0, n - 2);
                s2 = $urandom_range(s1 + 1, n - 1);
                qx = longint'($urandom_range(0, 200000)) - 100000;
                qy = longint'($urandom_range(0, 200000)) - 100000;
                da = longint'($urandom_range(0, 10000)) - 5000;
                db = longint'($urandom_range(0, 10000)) - 5000;
                if ($urandom_range(0, 1) == 1) begin
                    push_load(s1, ID_W'($urandom), clamp_coord(qx + da), clamp_coord(qy + db));
                    push_load(s2, ID_W'($urandom), clamp_coord(qx - db), clamp_coord(qy + da));
                end else begin
                    push_load(s2, ID_W'($urandom), clamp_coord(qx + da), clamp_coord(qy + db));
                    push_load(s1, ID_W'($urandom), clamp_coord(qx - db), clamp_coord(qy + da));
                end
                push_query(COORD_W'(qx), COORD_W'(qy));
                i += 3;
            end else begin
                if (n > 0 && $urandom_range(0, 99) < 40) begin
                    j = $urandom_range(0, n - 1);
                    qx = longint'(gen_x[j]) + longint'($urandom_range(0, 600)) - 300;
                    qy = longint'(gen_y[j]) + longint'($urandom_range(0, 600)) - 300;
                    push_query(clamp_coord(qx), clamp_coord(qy));
                end else begin
                    push_query(rand_coord(), rand_coord());
                end
                i++;
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            send_busy = s_tvalid;
            if (s_tvalid && o_s_tready) begin
                take_request(cur_req);
                send_busy = 1'b0;
                send_gap = no_idle ? 0 : pick_gap();
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    s_tdata <= {2'b00, cur_req.py, cur_req.px, cur_req.ident, cur_req.slot};
                    s_tuser <= cur_req.kind;
                    send_busy = 1'b1;
                end
            end
            s_tvalid <= send_busy;
        end
    end

    // answer monitor
    always @(posedge i_clk) begin
        t_answer want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("unexpected answer: found=%0d data=%h", o_m_tuser, o_m_tdata);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_m_tuser !== want.found || o_m_tdata[15:0] !== want.ident ||
                        o_m_tdata[39:16] !== want.nx || o_m_tdata[63:40] !== want.ny) begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display("mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                                     want.found, want.ident, want.nx, want.ny, o_m_tuser,
                                     o_m_tdata[15:0], $signed(o_m_tdata[39:16]),
                                     $signed(o_m_tdata[63:40]));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_nearest_landmark_association: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int order [MAX_LANDMARKS];
        int k;
        int j;
        int tmp;
        int phase;
        logic [CNT_W-1:0] counts [10];
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // empty scan: nothing to match, all fields zero
        set_count(0);
        push_query(C_MAX, C_MIN);
        push_query('0, '0);
        push_load(0, 16'hFFFF, C_MAX, C_MAX);
        push_load(1, 16'h0000, C_MIN, C_MIN);
        push_load(2, 16'h1234, '0, '0);
        push_load(3, 16'hA5A5, '0, '0);    // same spot as slot 2
        push_load(63, 16'h8001, C_MIN, C_MAX);

        // single entry, farthest possible observation
        set_count(1);
        push_query(C_MIN, C_MIN);

        set_count(4);
        push_query('0, '0);
        push_query(C_MIN, C_MIN);
        push_query(C_MAX, C_MAX);
        push_query(24'sd1, -24'sd1);

        // fill the whole map in random order with queries in between
        for (k = 0; k < MAX_LANDMARKS; k++) order[k] = k;
        for (k = MAX_LANDMARKS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        no_idle = 1'b1;
        for (k = 0; k < MAX_LANDMARKS; k++) begin
            push_load(order[k], ID_W'($urandom), rand_coord(), rand_coord());
            if ($urandom_range(0, 2) != 0) push_query(rand_coord(), rand_coord());
        end
        wait_drained();
        no_idle = 1'b0;

        counts = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd65, 7'd2, 7'd100,
                   CNT_W'($urandom_range(1, 64)), 7'd64, CNT_W'($urandom_range(3, 16))};
        for (phase = 0; phase < 10; phase++) begin
            set_count(counts[phase]);
            no_idle = (phase % 4 == 2);
            run_mixed(84);
        end

        wait_drained();
        if (pending_answers.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("tb_nearest_landmark_association: done, clean");
        end else begin
            $display("tb_nearest_landmark_association: done, errors");
        end
        $finish;
    end
endmodule
